>>> src/prqd_pkg.sv
// shared types and constants for the pending request queue drain block
package prqd_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int CMDQ_DEPTH      = 2;

	localparam int INODE_W  = 32;
	localparam int OFFSET_W = 48;
	localparam int DEVBLK_W = 32;
	localparam int BLK_W    = 32;
	localparam int SHIFT_W  = 5;
	localparam int STATUS_W = 2;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

	// register index, taken from the word address bit
	localparam logic REG_BLOCK_SIZE_SHIFT = 1'b0;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		CMD_ENQ   = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		EX_IDLE,
		EX_SCAN,
		EX_POP_RD,
		EX_POP_EMIT
	} exec_state_t;

	typedef enum logic {
		SCAN_CLEAR,
		SCAN_FIND
	} scan_mode_t;

	// classified command as it sits in the queue between front and back
	typedef struct packed {
		cmd_t                cmd;
		logic [INODE_W-1:0]  inode;
		logic [OFFSET_W-1:0] offset;
		logic [DEVBLK_W-1:0] dev;
		logic [BLK_W-1:0]    blk;
		logic                too_large;
	} req_t;

endpackage

>>> src/prqd_front.sv
// front end: takes commands and works out the block number and range check
module prqd_front (
	input  logic                           start,
	input  logic                           command,
	input  logic [prqd_pkg::INODE_W-1:0]   inode_number,
	input  logic [prqd_pkg::OFFSET_W-1:0]  byte_offset,
	input  logic [prqd_pkg::DEVBLK_W-1:0]  device_block,
	input  logic [prqd_pkg::SHIFT_W-1:0]   shift,
	input  logic                           q_full,
	output logic                           busy,
	output logic                           push,
	output prqd_pkg::req_t                 req
);

	logic [prqd_pkg::OFFSET_W-1:0] shifted;

	assign shifted = byte_offset >> shift;
	assign busy    = q_full;
	assign push    = start && !q_full;

	always_comb begin
		req.cmd       = prqd_pkg::cmd_t'(command);
		req.inode     = inode_number;
		req.offset    = byte_offset;
		req.dev       = device_block;
		req.blk       = shifted[prqd_pkg::BLK_W-1:0];
		// block number of 2^32 or more
		req.too_large = |shifted[prqd_pkg::OFFSET_W-1:prqd_pkg::BLK_W];
	end

endmodule

>>> src/prqd_cmdq.sv
// short command queue between the front end and the executor
module prqd_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  prqd_pkg::req_t push_data,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output prqd_pkg::req_t head
);

	localparam int PTR_W = (prqd_pkg::CMDQ_DEPTH > 1) ? $clog2(prqd_pkg::CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(prqd_pkg::CMDQ_DEPTH + 1);

	prqd_pkg::req_t   slots_q [prqd_pkg::CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(prqd_pkg::CMDQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full    = (count_q == CNT_W'(prqd_pkg::CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> src/prqd_exec.sv
// executor: circular request store, target marks, key scans and drain pops
module prqd_exec #(
	parameter int QUEUE_DEPTH = prqd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [prqd_pkg::SHIFT_W-1:0]   shift,
	input  logic                           q_empty,
	input  prqd_pkg::req_t                 q_head,
	output logic                           q_pop,
	output logic                           strobe,
	output logic [prqd_pkg::STATUS_W-1:0]  status,
	output logic [prqd_pkg::INODE_W-1:0]   out_inode,
	output logic [prqd_pkg::OFFSET_W-1:0]  out_offset,
	output logic [prqd_pkg::DEVBLK_W-1:0]  out_device_block,
	output logic                           last
);

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [prqd_pkg::INODE_W-1:0]  inode;
		logic [prqd_pkg::OFFSET_W-1:0] offset;
		logic [prqd_pkg::DEVBLK_W-1:0] dev;
	} entry_t;

	typedef struct packed {
		prqd_pkg::status_t             status;
		logic [prqd_pkg::INODE_W-1:0]  inode;
		logic [prqd_pkg::OFFSET_W-1:0] offset;
		logic [prqd_pkg::DEVBLK_W-1:0] dev;
		logic                          last;
	} res_t;

	// request store and target marks
	entry_t data_mem [QUEUE_DEPTH];
	logic   tgt_mem  [QUEUE_DEPTH];
	entry_t rd_entry_q;
	logic   rd_tgt_q;

	prqd_pkg::exec_state_t state_q, state_d;
	prqd_pkg::scan_mode_t  mode_q, mode_d;

	logic [SLOT_W-1:0] head_q, head_d;
	logic [SLOT_W-1:0] tail_q, tail_d;
	logic [OCC_W-1:0]  occ_q, occ_d;
	logic [SLOT_W-1:0] scan_slot_q, scan_slot_d;
	logic [OCC_W-1:0]  scan_cnt_q, scan_cnt_d;
	logic [OCC_W-1:0]  scan_len_q, scan_len_d;
	logic              cmp_vld_q, cmp_vld_d;
	logic [SLOT_W-1:0] cmp_slot_q, cmp_slot_d;
	logic [OCC_W-1:0]  cmp_k_q, cmp_k_d;
	logic [OCC_W-1:0]  pop_left_q, pop_left_d;
	logic [OCC_W-1:0]  rem_len_q, rem_len_d;
	logic [SLOT_W-1:0] clr_base_q, clr_base_d;
	logic              res_vld_q, res_vld_d;
	res_t              res_q, res_d;

	logic [prqd_pkg::INODE_W-1:0] key_inode_q, key_inode_d;
	logic [prqd_pkg::BLK_W-1:0]   key_blk_q, key_blk_d;

	logic [SLOT_W-1:0]          rd_addr;
	logic [prqd_pkg::BLK_W-1:0] rd_blk;
	logic [prqd_pkg::OFFSET_W-1:0] rd_shifted;
	logic                       key_hit;
	logic                       scan_issue;
	logic                       scan_done;
	logic                       mem_we;
	entry_t                     mem_wdata;
	logic                       tgt_we;
	logic [SLOT_W-1:0]          tgt_waddr;
	logic                       tgt_wdata;

	function automatic logic [SLOT_W-1:0] inc_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	assign rd_addr    = (state_q == prqd_pkg::EX_POP_RD) ? head_q : scan_slot_q;
	assign rd_shifted = rd_entry_q.offset >> shift;
	assign rd_blk     = rd_shifted[prqd_pkg::BLK_W-1:0];
	assign key_hit    = cmp_vld_q && (rd_entry_q.inode == key_inode_q) && (rd_blk == key_blk_q);
	assign scan_issue = (state_q == prqd_pkg::EX_SCAN) && (scan_cnt_q != scan_len_q);
	assign scan_done  = (state_q == prqd_pkg::EX_SCAN) && !scan_issue && !cmp_vld_q;
	assign mem_wdata  = '{inode: q_head.inode, offset: q_head.offset, dev: q_head.dev};

	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		head_d      = head_q;
		tail_d      = tail_q;
		occ_d       = occ_q;
		scan_slot_d = scan_slot_q;
		scan_cnt_d  = scan_cnt_q;
		scan_len_d  = scan_len_q;
		pop_left_d  = pop_left_q;
		rem_len_d   = rem_len_q;
		clr_base_d  = clr_base_q;
		key_inode_d = key_inode_q;
		key_blk_d   = key_blk_q;
		cmp_vld_d   = scan_issue;
		cmp_slot_d  = scan_slot_q;
		cmp_k_d     = scan_cnt_q;
		res_vld_d   = 1'b0;
		res_d       = res_q;
		q_pop       = 1'b0;
		mem_we      = 1'b0;
		tgt_we      = 1'b0;
		tgt_waddr   = cmp_slot_q;
		tgt_wdata   = 1'b0;

		case (state_q)
			prqd_pkg::EX_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					res_vld_d = 1'b1;
					res_d = '{status: prqd_pkg::ST_OK, inode: '0, offset: '0, dev: '0,
						last: 1'b1};
					if (q_head.cmd == prqd_pkg::CMD_ENQ) begin
						if (occ_q == OCC_W'(QUEUE_DEPTH)) begin
							res_d.status = prqd_pkg::ST_FULL;
						end else if (q_head.too_large) begin
							res_d.status = prqd_pkg::ST_TOO_LARGE;
						end else begin
							// store at the tail, then clear older marks with the same key
							mem_we      = 1'b1;
							tgt_we      = 1'b1;
							tgt_waddr   = tail_q;
							tgt_wdata   = 1'b1;
							key_inode_d = q_head.inode;
							key_blk_d   = q_head.blk;
							scan_slot_d = head_q;
							scan_cnt_d  = '0;
							scan_len_d  = occ_q;
							mode_d      = prqd_pkg::SCAN_CLEAR;
							pop_left_d  = '0;
							tail_d      = inc_slot(tail_q);
							occ_d       = occ_q + OCC_W'(1);
							state_d     = (occ_q == '0) ? prqd_pkg::EX_IDLE : prqd_pkg::EX_SCAN;
						end
					end else begin
						if (q_head.too_large) begin
							res_d.status = prqd_pkg::ST_TOO_LARGE;
						end else if (occ_q == '0) begin
							res_d.status = prqd_pkg::ST_NOT_FOUND;
						end else begin
							res_vld_d   = 1'b0;
							key_inode_d = q_head.inode;
							key_blk_d   = q_head.blk;
							scan_slot_d = head_q;
							scan_cnt_d  = '0;
							scan_len_d  = occ_q;
							mode_d      = prqd_pkg::SCAN_FIND;
							state_d     = prqd_pkg::EX_SCAN;
						end
					end
				end
			end

			prqd_pkg::EX_SCAN: begin
				if (scan_issue) begin
					scan_slot_d = inc_slot(scan_slot_q);
					scan_cnt_d  = scan_cnt_q + OCC_W'(1);
				end
				if (mode_q == prqd_pkg::SCAN_CLEAR) begin
					if (key_hit) begin
						tgt_we = 1'b1;
					end
					if (scan_done) begin
						state_d = (pop_left_q != '0) ? prqd_pkg::EX_POP_RD : prqd_pkg::EX_IDLE;
					end
				end else begin
					if (key_hit && rd_tgt_q) begin
						// first marked match from the head: pop up to and including it
						pop_left_d = cmp_k_q + OCC_W'(1);
						rem_len_d  = occ_q - cmp_k_q - OCC_W'(1);
						clr_base_d = inc_slot(cmp_slot_q);
						cmp_vld_d  = 1'b0;
						state_d    = prqd_pkg::EX_POP_RD;
					end else if (scan_done) begin
						res_vld_d = 1'b1;
						res_d = '{status: prqd_pkg::ST_NOT_FOUND, inode: '0, offset: '0,
							dev: '0, last: 1'b1};
						state_d = prqd_pkg::EX_IDLE;
					end
				end
			end

			prqd_pkg::EX_POP_RD: begin
				state_d = prqd_pkg::EX_POP_EMIT;
			end

			prqd_pkg::EX_POP_EMIT: begin
				res_vld_d = 1'b1;
				res_d = '{status: prqd_pkg::ST_OK, inode: rd_entry_q.inode,
					offset: rd_entry_q.offset, dev: rd_entry_q.dev,
					last: (pop_left_q == OCC_W'(1))};
				head_d      = inc_slot(head_q);
				occ_d       = occ_q - OCC_W'(1);
				pop_left_d  = pop_left_q - OCC_W'(1);
				key_inode_d = rd_entry_q.inode;
				key_blk_d   = rd_blk;
				if (rem_len_q != '0) begin
					// popped key drops the marks of matching entries that stay queued
					scan_slot_d = clr_base_q;
					scan_cnt_d  = '0;
					scan_len_d  = rem_len_q;
					mode_d      = prqd_pkg::SCAN_CLEAR;
					state_d     = prqd_pkg::EX_SCAN;
				end else begin
					state_d = (pop_left_q == OCC_W'(1)) ? prqd_pkg::EX_IDLE : prqd_pkg::EX_POP_RD;
				end
			end

			default: begin
				state_d = prqd_pkg::EX_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prqd_pkg::EX_IDLE;
			mode_q      <= prqd_pkg::SCAN_CLEAR;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			scan_slot_q <= '0;
			scan_cnt_q  <= '0;
			scan_len_q  <= '0;
			cmp_vld_q   <= 1'b0;
			pop_left_q  <= '0;
			rem_len_q   <= '0;
			res_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			mode_q      <= mode_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			occ_q       <= occ_d;
			scan_slot_q <= scan_slot_d;
			scan_cnt_q  <= scan_cnt_d;
			scan_len_q  <= scan_len_d;
			cmp_vld_q   <= cmp_vld_d;
			pop_left_q  <= pop_left_d;
			rem_len_q   <= rem_len_d;
			res_vld_q   <= res_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		cmp_slot_q  <= cmp_slot_d;
		cmp_k_q     <= cmp_k_d;
		clr_base_q  <= clr_base_d;
		key_inode_q <= key_inode_d;
		key_blk_q   <= key_blk_d;
		res_q       <= res_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			data_mem[tail_q] <= mem_wdata;
		end
		if (tgt_we) begin
			tgt_mem[tgt_waddr] <= tgt_wdata;
		end
		rd_entry_q <= data_mem[rd_addr];
		rd_tgt_q   <= tgt_mem[rd_addr];
	end

	assign strobe           = res_vld_q;
	assign status           = res_q.status;
	assign out_inode        = res_q.inode;
	assign out_offset       = res_q.offset;
	assign out_device_block = res_q.dev;
	assign last             = res_q.last;

	logic [OCC_W:0]    tail_sum;
	logic [OCC_W:0]    tail_wrap;

	assign tail_sum  = (OCC_W+1)'(head_q) + (OCC_W+1)'(occ_q);
	assign tail_wrap = (tail_sum >= (OCC_W+1)'(QUEUE_DEPTH)) ?
		tail_sum - (OCC_W+1)'(QUEUE_DEPTH) : tail_sum;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	a_tail_track: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q == SLOT_W'(tail_wrap))
		else $error("tail does not sit at head plus occupancy");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && (res_q.status != prqd_pkg::ST_OK)) |-> res_q.last)
		else $error("error result not marked last");

	a_pop_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == prqd_pkg::EX_POP_EMIT) |-> (occ_q != '0))
		else $error("pop from an empty queue");

	a_compare_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != prqd_pkg::EX_SCAN) |-> !cmp_vld_q)
		else $error("key compare pending outside a scan");

endmodule

>>> src/pending_request_queue_drain.sv
// top level: config register, front end, command queue and executor
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-------------------------------------------
//  command   | start / busy                   | command, inode_number, byte_offset,
//            |                                | device_block
//  result    | strobe (one cycle, no stall)   | status, out_inode, out_offset,
//            |                                | out_device_block, last
//  config    | apb psel/penable/pwrite/pready | paddr, pwdata, prdata (block_size_shift)
//
// a transaction waits in the command queue until the executor is free; error, enqueue and empty-queue
// not-found results then come straight from the idle state through the result register.
// a successful enqueue into a non-empty queue then holds the executor while it scans for older targets
// of its key; a drain scans from the head for the first marked match (or to the end for a miss),
// then pops each entry up to it, rescanning the entries that stay queued after each pop to clear
// their marks. the single read port of the request store bounds all of this to one entry visited
// per cycle. reset clears pointers, occupancy and control state and loads the default shift, but
// not the stores; busy rises when the two-deep command queue fills.
module pending_request_queue_drain #(
	parameter int QUEUE_DEPTH = prqd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           command,
	input  logic [prqd_pkg::INODE_W-1:0]   inode_number,
	input  logic [prqd_pkg::OFFSET_W-1:0]  byte_offset,
	input  logic [prqd_pkg::DEVBLK_W-1:0]  device_block,
	output logic                           strobe,
	output logic [prqd_pkg::STATUS_W-1:0]  status,
	output logic [prqd_pkg::INODE_W-1:0]   out_inode,
	output logic [prqd_pkg::OFFSET_W-1:0]  out_offset,
	output logic [prqd_pkg::DEVBLK_W-1:0]  out_device_block,
	output logic                           last,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [prqd_pkg::APB_AW-1:0]    paddr,
	input  logic [prqd_pkg::APB_DW-1:0]    pwdata,
	output logic [prqd_pkg::APB_DW-1:0]    prdata,
	output logic                           pready
);

	logic [prqd_pkg::SHIFT_W-1:0] shift_q;
	logic                         reg_sel;
	logic                         cfg_wr;
	logic                         push;
	prqd_pkg::req_t               push_req;
	logic                         q_full;
	logic                         q_empty;
	logic                         q_pop;
	prqd_pkg::req_t               q_head;

	// word address bit picks the register
	assign reg_sel = (paddr[2] == prqd_pkg::REG_BLOCK_SIZE_SHIFT);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? prqd_pkg::APB_DW'(shift_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= prqd_pkg::SHIFT_RESET;
		end else if (cfg_wr) begin
			shift_q <= pwdata[prqd_pkg::SHIFT_W-1:0];
		end
	end

	prqd_front u_front (
		.start        (start),
		.command      (command),
		.inode_number (inode_number),
		.byte_offset  (byte_offset),
		.device_block (device_block),
		.shift        (shift_q),
		.q_full       (q_full),
		.busy         (busy),
		.push         (push),
		.req          (push_req)
	);

	prqd_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_req),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	prqd_exec #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_exec (
		.clk              (clk),
		.arst_n           (arst_n),
		.shift            (shift_q),
		.q_empty          (q_empty),
		.q_head           (q_head),
		.q_pop            (q_pop),
		.strobe           (strobe),
		.status           (status),
		.out_inode        (out_inode),
		.out_offset       (out_offset),
		.out_device_block (out_device_block),
		.last             (last)
	);

endmodule
